/* rtl/core/ibad_pkg.sv */
// ----------------------------------------------------------------------------
// ibad_pkg
// Shared types and constants of the IR beacon angle/distance block.
// ----------------------------------------------------------------------------
package ibad_pkg;

    localparam int TIMER_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int STAMP_W  = 16;
    localparam int ANGLE_W  = 19;
    localparam int DIST_W   = 19;
    localparam int CIDX_W   = 2;
    localparam int CDATA_W  = 9;

    localparam int ANGLE_FULL   = 360000;
    localparam int MDEG_PER_DEG = 1000;
    localparam int QBITS        = 24;
    localparam int DIST_MAX     = 1000;
    localparam int DIST_MIN     = -140000;
    localparam int DIST_BIAS    = 16;

    // cubic coefficients scaled by 1e5
    localparam logic signed [31:0] COEF3 = -32'sd240250;
    localparam logic signed [31:0] COEF2 = 32'sd118320;
    localparam logic signed [31:0] COEF1 = -32'sd15460;
    localparam logic signed [31:0] COEF0 = 32'sd620;

    typedef enum logic [1:0] {
        KIND_MARK = 2'd0,
        KIND_RISE = 2'd1,
        KIND_FALL = 2'd2,
        KIND_TICK = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_NEW  = 2'd0,
        ST_HOLD = 2'd1,
        ST_LOST = 2'd2
    } t_status;

    typedef enum logic [CIDX_W-1:0] {
        CFG_OFFSET = 2'd0,
        CFG_REJ_LO = 2'd1,
        CFG_REJ_HI = 2'd2,
        CFG_LOST   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [8:0] mounting_offset_deg;
        logic [8:0] reject_low_deg;
        logic [8:0] reject_high_deg;
        logic [7:0] lost_after;
    } t_cfg;

endpackage

/* rtl/core/ibad_if.sv */
// ----------------------------------------------------------------------------
// ibad_if
// Valid/ready channels: capture/tick requests, results, register writes.
// ----------------------------------------------------------------------------
interface ibad_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] stamp;
    logic        overflow;

    modport source (output valid, kind, stamp, overflow, input ready);
    modport sink   (input valid, kind, stamp, overflow, output ready);
endinterface

interface ibad_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [18:0]        angle_mdeg;
    logic signed [18:0] distance;

    modport source (output valid, status, angle_mdeg, distance, input ready);
    modport sink   (input valid, status, angle_mdeg, distance, output ready);
endinterface

interface ibad_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [8:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/ir_beacon_angle_distance.sv */
// ----------------------------------------------------------------------------
// ir_beacon_angle_distance
// Angle and distance of a spinning IR beacon from captured timer stamps.
// ----------------------------------------------------------------------------
// channel  dir  payload                          request
// i_in     in   kind, stamp, overflow            capture event or compute tick
// o_out    out  status, angle_mdeg, distance     one per compute tick
// i_cfg    in   index, data                      register write, always ready
//
// Capture events are taken one per cycle while the tick queue has room.
// A tick is solved with up to three divisions by the filtered period on the
// shared restoring divider, one quotient bit per cycle.
// Reset is synchronous; registers return to their default values.
// A stalled result holds the solver; the front keeps taking captures and
// queues up to QUEUE_DEPTH ticks.
// ----------------------------------------------------------------------------
module ir_beacon_angle_distance #(
    parameter int TIMER_BITS  = ibad_pkg::TIMER_BITS_DEF,
    parameter int QUEUE_DEPTH = ibad_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ibad_in_if.sink     i_in,
    ibad_out_if.source  o_out,
    ibad_cfg_if.sink    i_cfg
);
    import ibad_pkg::*;

    localparam int JW = 3 * (TIMER_BITS + 1) + 2;

    t_cfg          r_cfg;
    logic          q_full, q_push, q_valid, q_pop;
    logic [JW-1:0] q_in, q_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mounting_offset_deg <= 9'd180;
            r_cfg.reject_low_deg      <= 9'd85;
            r_cfg.reject_high_deg     <= 9'd275;
            r_cfg.lost_after          <= 8'd25;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_OFFSET: r_cfg.mounting_offset_deg <= i_cfg.data;
                CFG_REJ_LO: r_cfg.reject_low_deg      <= i_cfg.data;
                CFG_REJ_HI: r_cfg.reject_high_deg     <= i_cfg.data;
                CFG_LOST:   r_cfg.lost_after          <= i_cfg.data[7:0];
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    ibad_front #(.TIMER_BITS(TIMER_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (q_in)
    );

    ibad_queue #(.W(JW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    ibad_back #(.TIMER_BITS(TIMER_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_out),
        .o_job_pop   (q_pop),
        .i_cfg       (r_cfg),
        .o_out       (o_out)
    );

endmodule

/* rtl/core/ibad_div.sv */
// ----------------------------------------------------------------------------
// ibad_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ibad_div #(
    parameter int NW  = 42,
    parameter int DVW = 19
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [NW-1:0]  i_dividend,
    input  logic [DVW-1:0] i_divisor,
    output logic           o_busy,
    output logic           o_done,
    output logic [NW-1:0]  o_quot,
    output logic [DVW-1:0] o_rem
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]  r_q;
    logic [DVW-1:0] r_r;
    logic [DVW-1:0] r_d;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [DVW:0] n_sh;
    logic [DVW:0] n_diff;
    logic         n_ge;

    assign n_sh   = {r_r, r_q[NW-1]};
    assign n_ge   = (n_sh >= {1'b0, r_d});
    assign n_diff = n_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_r    <= '0;
                r_d    <= i_divisor;
                r_cnt  <= CW'(NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_r   <= n_ge ? n_diff[DVW-1:0] : n_sh[DVW-1:0];
                r_q   <= {r_q[NW-2:0], n_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

/* rtl/core/ibad_queue.sv */
// ----------------------------------------------------------------------------
// ibad_queue
// Short FIFO of tick jobs between the capture front end and the solver.
// ----------------------------------------------------------------------------
module ibad_queue #(
    parameter int W     = 53,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        f_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= f_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= f_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("job pushed into full queue");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job popped from empty queue");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count lost a job");

endmodule

/* rtl/core/ibad_front.sv */
// ----------------------------------------------------------------------------
// ibad_front
// Takes capture requests, keeps the latest stamps, snapshots them per tick.
// ----------------------------------------------------------------------------
module ibad_front #(
    parameter int TIMER_BITS = ibad_pkg::TIMER_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    ibad_in_if.sink                 i_in,
    input  logic                    i_full,
    output logic                    o_push,
    output logic [3*TIMER_BITS+4:0] o_job
);
    import ibad_pkg::*;

    localparam int TW = TIMER_BITS + 1;

    logic [TW-1:0] r_raw;
    logic [TW-1:0] r_rise;
    logic [TW-1:0] r_fall;
    logic          r_pend;
    logic          r_prdy;

    logic [TW-1:0] n_t;
    logic          n_acc;

    assign n_t   = {i_in.overflow, TIMER_BITS'(i_in.stamp)};
    assign n_acc = i_in.valid && i_in.ready;

    assign i_in.ready = !i_full;
    assign o_push     = n_acc && (t_kind'(i_in.kind) == KIND_TICK);
    assign o_job      = {r_pend, r_raw, r_rise, r_fall, r_prdy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw  <= '0;
            r_rise <= '0;
            r_fall <= '0;
            r_pend <= 1'b0;
            r_prdy <= 1'b0;
        end else if (n_acc) begin
            case (t_kind'(i_in.kind))
                KIND_MARK: begin
                    r_raw  <= n_t;
                    r_pend <= 1'b1;
                end
                KIND_RISE: begin
                    r_rise <= n_t;
                    r_prdy <= 1'b0;
                end
                KIND_FALL: begin
                    r_fall <= n_t;
                    r_prdy <= 1'b1;
                end
                default: begin
                    // tick: snapshot taken by the queue, consume flags
                    r_pend <= 1'b0;
                    r_prdy <= 1'b0;
                end
            endcase
        end
    end

endmodule

/* rtl/core/ibad_back.sv */
// ----------------------------------------------------------------------------
// ibad_back
// Tick solver: period filter, pulse centre, angle, width filter, cubic fit.
// ----------------------------------------------------------------------------
module ibad_back #(
    parameter int TIMER_BITS = ibad_pkg::TIMER_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_job_valid,
    input  logic [3*TIMER_BITS+4:0] i_job,
    output logic                    o_job_pop,
    input  ibad_pkg::t_cfg          i_cfg,
    ibad_out_if.source              o_out
);
    import ibad_pkg::*;

    localparam int TW  = TIMER_BITS + 1;
    localparam int WW  = TW + 3;
    localparam int NW  = TW + 26;
    localparam int DVW = (TW > 19) ? TW : 19;
    localparam int XW  = 26;
    localparam int PW  = 58;

    // ceil(2^32/5): exact quotient by 5 for operands below 2^30
    localparam logic [31:0] DIV5_MUL = 32'd858993460;

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_PER  = 15'b000000000000010,
        S_PREP = 15'b000000000000100,
        S_MODP = 15'b000000000001000,
        S_MULA = 15'b000000000010000,
        S_ANG  = 15'b000000000100000,
        S_OFF  = 15'b000000001000000,
        S_REJ  = 15'b000000010000000,
        S_RND  = 15'b000000100000000,
        S_WF   = 15'b000001000000000,
        S_DIST = 15'b000010000000000,
        S_X    = 15'b000100000000000,
        S_HORN = 15'b001000000000000,
        S_FIN  = 15'b010000000000000,
        S_OUT  = 15'b100000000000000
    } t_state;

    t_state r_state;

    // persistent state
    logic [TW-1:0]        r_pf;
    logic signed [WW-1:0] r_wf;
    logic [7:0]           r_miss;

    // job snapshot and working registers
    logic [TW-1:0]        r_raw, r_rise, r_fall;
    logic                 r_pend, r_prdy;
    logic signed [WW-1:0] r_w, r_wr;
    logic                 r_wrap;
    logic [TW-1:0]        r_mid;
    logic [NW-1:0]        r_prod;
    logic [NW-1:0]        r_a;
    logic [ANGLE_W-1:0]   r_angle;
    logic signed [XW-1:0] r_x;
    logic signed [PW-1:0] r_prd;
    logic signed [31:0]   r_t;
    logic [2:0]           r_hs;
    logic signed [DIST_W-1:0] r_dist;
    logic                 r_ok;
    logic                 r_issued;
    logic                 r_dstart;

    // result register
    logic               r_ovalid;
    logic [1:0]         r_ostatus;
    logic [ANGLE_W-1:0] r_oangle;
    logic [DIST_W-1:0]  r_odist;

    // divider
    logic [NW-1:0]  n_dn;
    logic [DVW-1:0] n_dd;
    logic           d_busy, d_done;
    logic [NW-1:0]  d_quot;
    logic [DVW-1:0] d_rem;

    ibad_div #(.NW(NW), .DVW(DVW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dstart),
        .i_dividend (n_dn),
        .i_divisor  (n_dd),
        .o_busy     (d_busy),
        .o_done     (d_done),
        .o_quot     (d_quot),
        .o_rem      (d_rem)
    );

    logic signed [WW-1:0]   s_p, s_r, s_f;
    logic signed [WW-1:0]   n_wwrap, n_wlin, n_adj, n_half, n_v, n_rn;
    logic signed [WW-1:0]   n_q10, n_qw, n_wfm;
    logic signed [WW+2:0]   n_n4, n_m4;
    logic signed [XW-1:0]   n_qx;
    logic [ANGLE_W-1:0]     n_off, n_lo, n_hi;
    logic signed [31:0]     n_coef, n_tn;
    logic signed [DIST_W-1:0] n_sat;
    logic [31:0]            n_pnum, n_pq, n_rq, n_r10, n_wq;
    logic [ANGLE_W:0]       n_asum;
    logic [ANGLE_W-1:0]     n_angle;

    function automatic logic signed [31:0] f_tr(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] b;
        b = v[PW-1] ? (v + PW'((1 << QBITS) - 1)) : v;
        f_tr = 32'(b >>> QBITS);
    endfunction

    function automatic logic [31:0] f_div5(input logic [31:0] v);
        logic [63:0] p;
        p = {32'd0, v} * {32'd0, DIV5_MUL};
        f_div5 = p[63:32];
    endfunction

    always_comb begin
        s_p     = signed'(WW'(r_pf));
        s_r     = signed'(WW'(r_rise));
        s_f     = signed'(WW'(r_fall));
        n_wwrap = s_p - s_r + s_f;
        n_wlin  = s_f - s_r;
        n_adj   = r_w[WW-1] ? r_w + 1 : r_w;  // halve toward zero
        n_half  = n_adj >>> 1;
        n_v     = n_half + s_r + s_p;
        n_rn    = r_w[WW-1] ? -r_w : r_w + 9;
        n_pnum  = (32'(r_pf) << 2) + 32'(r_raw);
        n_pq    = f_div5(n_pnum);
        // n/10 as (n/2)/5
        n_rq    = f_div5(32'(unsigned'(n_rn)) >> 1);
        n_r10   = n_rq * 32'd10;
        n_q10   = signed'(n_r10[WW-1:0]);
        n_n4    = ((WW+3)'(r_wf) <<< 2) + (WW+3)'(r_wr);
        n_m4    = n_n4[WW+2] ? -n_n4 : n_n4;
        n_wq    = f_div5(32'(unsigned'(n_m4)));
        n_qw    = signed'(n_wq[WW-1:0]);
        n_wfm   = r_wf[WW-1] ? -r_wf : r_wf;
        n_qx    = signed'(XW'(d_quot));
        n_off   = ANGLE_W'(i_cfg.mounting_offset_deg) * ANGLE_W'(MDEG_PER_DEG);
        n_lo    = ANGLE_W'(i_cfg.reject_low_deg) * ANGLE_W'(MDEG_PER_DEG);
        n_hi    = ANGLE_W'(i_cfg.reject_high_deg) * ANGLE_W'(MDEG_PER_DEG);
        // base angle is below a full turn, so one subtract wraps the sum while the offset is below 360 degrees
        n_asum  = {1'b0, r_a[ANGLE_W-1:0]} + {1'b0, n_off};
        n_angle = (n_asum >= (ANGLE_W+1)'(ANGLE_FULL)) ?
                  ANGLE_W'(n_asum - (ANGLE_W+1)'(ANGLE_FULL)) : n_asum[ANGLE_W-1:0];
        case (r_hs)
            3'd1:    n_coef = COEF2;
            3'd3:    n_coef = COEF1;
            default: n_coef = COEF0 + 32'(DIST_BIAS);
        endcase
        n_tn = n_coef + f_tr(r_prd);
        if (n_tn > DIST_MAX) begin
            n_sat = DIST_W'(DIST_MAX);
        end else if (n_tn < DIST_MIN) begin
            n_sat = DIST_W'(DIST_MIN);
        end else begin
            n_sat = DIST_W'(n_tn);
        end
    end

    always_comb begin
        n_dn = '0;
        n_dd = DVW'(1);
        case (r_state)
            S_MODP: begin
                // centre reduced modulo the period in both cases
                n_dn = r_wrap ? NW'(unsigned'(n_v)) : NW'(r_mid);
                n_dd = DVW'(r_pf);
            end
            S_ANG: begin
                n_dn = r_prod;
                n_dd = DVW'(r_pf);
            end
            S_X: begin
                n_dn = NW'(unsigned'(n_wfm)) << QBITS;
                n_dd = DVW'(r_pf);
            end
            default: begin
                n_dn = '0;
                n_dd = DVW'(1);
            end
        endcase
    end

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pf     <= '0;
            r_wf     <= '0;
            r_miss   <= '0;
            r_ovalid <= 1'b0;
            r_issued <= 1'b0;
            r_dstart <= 1'b0;
            r_hs     <= '0;
            r_ok     <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        {r_pend, r_raw, r_rise, r_fall, r_prdy} <= i_job;
                        r_ok    <= 1'b0;
                        r_state <= S_PER;
                    end
                end
                S_PER: begin
                    if (r_pend) begin
                        r_pf <= n_pq[TW-1:0];
                    end
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    if (!r_prdy || r_pf == '0) begin
                        r_state <= S_FIN;
                    end else if (r_rise > r_fall) begin
                        r_w     <= n_wwrap;
                        r_wrap  <= 1'b1;
                        r_state <= S_MODP;
                    end else begin
                        r_w     <= n_wlin;
                        r_wrap  <= 1'b0;
                        r_mid   <= TW'(unsigned'(s_r + (n_wlin >>> 1)));
                        r_state <= S_MODP;
                    end
                end
                S_MODP: begin
                    if (!r_issued) begin
                        r_dstart <= 1'b1;
                        r_issued <= 1'b1;
                    end else if (d_done) begin
                        r_issued <= 1'b0;
                        r_mid    <= TW'(d_rem);
                        r_state  <= S_MULA;
                    end
                end
                S_MULA: begin
                    r_prod  <= NW'(r_mid) * NW'(ANGLE_FULL);
                    r_state <= S_ANG;
                end
                S_ANG: begin
                    if (!r_issued) begin
                        r_dstart <= 1'b1;
                        r_issued <= 1'b1;
                    end else if (d_done) begin
                        r_issued <= 1'b0;
                        r_a      <= d_quot;
                        r_state  <= S_OFF;
                    end
                end
                S_OFF: begin
                    r_angle <= n_angle;
                    r_state <= S_REJ;
                end
                S_REJ: begin
                    if (r_angle > n_lo && r_angle < n_hi) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    r_wr    <= r_w[WW-1] ? -n_q10 : n_q10;
                    r_state <= S_WF;
                end
                S_WF: begin
                    r_wf    <= n_n4[WW+2] ? -n_qw : n_qw;
                    r_state <= S_DIST;
                end
                S_DIST: begin
                    r_ok <= 1'b1;
                    if (r_wf <= -s_p) begin
                        r_dist  <= DIST_W'(DIST_MAX);
                        r_state <= S_FIN;
                    end else if (r_wf >= (s_p <<< 1)) begin
                        r_dist  <= DIST_W'(DIST_MIN);
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_X;
                    end
                end
                S_X: begin
                    if (!r_issued) begin
                        r_dstart <= 1'b1;
                        r_issued <= 1'b1;
                    end else if (d_done) begin
                        r_issued <= 1'b0;
                        r_x      <= r_wf[WW-1] ? -n_qx : n_qx;
                        r_t      <= COEF3;
                        r_hs     <= '0;
                        r_state  <= S_HORN;
                    end
                end
                S_HORN: begin
                    // even steps multiply, odd steps add the next coefficient
                    if (!r_hs[0]) begin
                        r_prd <= r_t * r_x;
                    end else begin
                        r_t <= n_tn;
                    end
                    r_hs <= r_hs + 1'b1;
                    if (r_hs == 3'd5) begin
                        r_dist  <= n_sat;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_ovalid <= 1'b1;
                    if (r_ok) begin
                        r_miss    <= '0;
                        r_ostatus <= ST_NEW;
                        r_oangle  <= r_angle;
                        r_odist   <= r_dist;
                    end else begin
                        r_oangle <= '0;
                        r_odist  <= '0;
                        if (r_miss < i_cfg.lost_after) begin
                            r_miss    <= r_miss + 1'b1;
                            r_ostatus <= ST_HOLD;
                        end else begin
                            r_ostatus <= ST_LOST;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.status     = r_ostatus;
    assign o_out.angle_mdeg = r_oangle;
    assign o_out.distance   = r_odist;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_NEW) |->
            (o_out.angle_mdeg == '0 && o_out.distance == '0))
        else $error("failed tick carries payload");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready) |=> !o_out.valid)
        else $error("result repeated");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dstart |-> !d_busy)
        else $error("divider restarted while busy");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_state == S_PER && !r_ovalid))
        else $error("job taken while solver busy");

endmodule

/* test/ibad_checker.sv */
// ----------------------------------------------------------------------------
// ibad_checker
// Watches the request, result and register channels of the beacon block,
// predicts each tick result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ibad_checker
    import ibad_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ibad_in_if   req_ch,
    ibad_out_if  res_ch,
    ibad_cfg_if  reg_ch,
    output int   o_pending,
    output int   o_errors
);

    typedef struct {
        t_status     status;
        logic [18:0] angle;
        logic [18:0] dist_est;
    } t_beacon_fix;

    t_beacon_fix expected_fixes[$];

    logic [8:0]  offset_deg;
    logic [8:0]  rej_lo_deg;
    logic [8:0]  rej_hi_deg;
    logic [7:0]  lost_limit;

    longint      turn_raw;
    bit          turn_pending;
    longint      turn_avg;
    longint      rise_at;
    longint      fall_at;
    bit          pulse_seen;
    longint      width_avg;
    int          misses;
    int          err_count;

    function automatic longint range_of(longint w, longint p);
        longint x;
        longint t;
        if (w <= -p)
            return DIST_MAX;
        if (w >= 2 * p)
            return DIST_MIN;
        x = (w * (64'sd1 <<< QBITS)) / p;
        t = 118320 + (-240250 * x) / (64'sd1 <<< QBITS);
        t = -15460 + (t * x) / (64'sd1 <<< QBITS);
        t = 620 + (t * x) / (64'sd1 <<< QBITS);
        t = t + DIST_BIAS;
        if (t > DIST_MAX)
            t = DIST_MAX;
        if (t < DIST_MIN)
            t = DIST_MIN;
        return t;
    endfunction

    // one tick: period filter, pulse geometry, window test, distance
    function automatic t_beacon_fix solve_tick();
        t_beacon_fix fx;
        longint      w;
        longint      mid;
        longint      ang;
        bit          ok;
        ok = 0;
        ang = 0;
        fx.dist_est = '0;
        if (turn_pending) begin
            turn_pending = 0;
            turn_avg = (4 * turn_avg + turn_raw) / 5;
        end
        if (pulse_seen) begin
            pulse_seen = 0;
            if (turn_avg > 0) begin
                if (rise_at > fall_at) begin
                    w   = turn_avg - rise_at + fall_at;
                    mid = (rise_at + w / 2 + turn_avg) % turn_avg;
                end else begin
                    w   = fall_at - rise_at;
                    mid = rise_at + w / 2;
                end
                ang = (mid * ANGLE_FULL) / turn_avg;
                ang = (ang + longint'(offset_deg) * MDEG_PER_DEG) % ANGLE_FULL;
                if (!(ang > longint'(rej_lo_deg) * MDEG_PER_DEG &&
                      ang < longint'(rej_hi_deg) * MDEG_PER_DEG)) begin
                    if (w >= 0)
                        w = ((w + 9) / 10) * 10;
                    else
                        w = -(((-w) / 10) * 10);
                    width_avg = (4 * width_avg + w) / 5;
                    fx.dist_est = 19'(range_of(width_avg, turn_avg));
                    ok = 1;
                end
            end
        end
        if (ok) begin
            misses    = 0;
            fx.status = ST_NEW;
            fx.angle  = 19'(ang);
        end else begin
            if (misses < lost_limit) begin
                misses++;
                fx.status = ST_HOLD;
            end else begin
                fx.status = ST_LOST;
            end
            fx.angle    = '0;
            fx.dist_est = '0;
        end
        return fx;
    endfunction

    always @(posedge i_clk) begin
        t_beacon_fix fx;
        longint      v;
        if (!i_rst_n) begin
            offset_deg   = 9'd180;
            rej_lo_deg   = 9'd85;
            rej_hi_deg   = 9'd275;
            lost_limit   = 8'd25;
            turn_raw     = 0;
            turn_pending = 0;
            turn_avg     = 0;
            rise_at      = 0;
            fall_at      = 0;
            pulse_seen   = 0;
            width_avg    = 0;
            misses       = 0;
            expected_fixes.delete();
        end else begin
            if (reg_ch.valid && reg_ch.ready) begin
                case (t_cfg_idx'(reg_ch.index))
                    CFG_OFFSET: offset_deg = reg_ch.data;
                    CFG_REJ_LO: rej_lo_deg = reg_ch.data;
                    CFG_REJ_HI: rej_hi_deg = reg_ch.data;
                    CFG_LOST:   lost_limit = reg_ch.data[7:0];
                    default:    ;
                endcase
            end
            if (res_ch.valid && res_ch.ready) begin
                if (expected_fixes.size() == 0) begin
                    $display("%0t: result with none expected: status %0d angle %0d dist %0d",
                             $time, res_ch.status, res_ch.angle_mdeg, res_ch.distance);
                    err_count++;
                end else begin
                    fx = expected_fixes.pop_front();
                    if (res_ch.status !== fx.status || res_ch.angle_mdeg !== fx.angle ||
                        res_ch.distance !== fx.dist_est) begin
                        $display("%0t: exp status %0d angle %0d dist %0d, got %0d %0d %0d",
                                 $time, fx.status, fx.angle, $signed(fx.dist_est),
                                 res_ch.status, res_ch.angle_mdeg, res_ch.distance);
                        err_count++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                v = {req_ch.overflow, req_ch.stamp};
                case (t_kind'(req_ch.kind))
                    KIND_MARK: begin
                        turn_raw     = v;
                        turn_pending = 1;
                    end
                    KIND_RISE: begin
                        rise_at    = v;
                        pulse_seen = 0;
                    end
                    KIND_FALL: begin
                        fall_at    = v;
                        pulse_seen = 1;
                    end
                    KIND_TICK: expected_fixes.push_back(solve_tick());
                    default:   ;
                endcase
            end
        end
        o_pending <= expected_fixes.size();
        o_errors  <= err_count;
    end

    final begin
        if (expected_fixes.size() != 0)
            $display("%0t: %0d results never arrived", $time, expected_fixes.size());
    end

endmodule

/* test/tb_ir_beacon_angle_distance.sv */
// ----------------------------------------------------------------------------
// tb_ir_beacon_angle_distance
// Drives capture events, ticks and register writes into the beacon block
// under several register settings and idle patterns; the checker predicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ir_beacon_angle_distance;
    import ibad_pkg::*;

    localparam int SETTLE_CYCLES = 400;
    localparam int STALL_LIMIT   = 40000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ibad_in_if  req_ch ();
    ibad_out_if res_ch ();
    ibad_cfg_if reg_ch ();

    int pending;
    int errors;
    int snd_idle_pct;
    int rcv_idle_pct;
    int quiet_cycles;
    int sent_items;
    int sent_ticks;
    int reg_writes;

    ir_beacon_angle_distance u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch),
        .i_cfg   (reg_ch)
    );

    ibad_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .req_ch    (req_ch),
        .res_ch    (res_ch),
        .reg_ch    (reg_ch),
        .o_pending (pending),
        .o_errors  (errors)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (reg_ch.valid && reg_ch.ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress, giving up", $time);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(t_kind k, logic [16:0] v);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.kind     <= k;
        req_ch.stamp    <= v[15:0];
        req_ch.overflow <= v[16];
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        sent_items++;
        if (k == KIND_TICK)
            sent_ticks++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [8:0] d);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= d;
        @(posedge i_clk);
        while (!reg_ch.ready)
            @(posedge i_clk);
        reg_ch.valid <= 1'b0;
        @(posedge i_clk);
        reg_writes++;
    endtask

    task automatic set_regs(int off, int lo, int hi, int lost);
        drain();
        write_reg(CFG_OFFSET, 9'(off));
        write_reg(CFG_REJ_LO, 9'(lo));
        write_reg(CFG_REJ_HI, 9'(hi));
        write_reg(CFG_LOST, 9'(lost));
    endtask

    // one turn of the beacon; sometimes broken or replaced by noise
    task automatic beacon_turn(int period);
        int r;
        int f;
        int w;
        int pick;
        pick = $urandom_range(0, 99);
        r = $urandom_range(0, period - 1);
        w = $urandom_range(1, period / 6 + 1);
        f = r + w;
        if (f >= period)
            f = f - period;
        if (pick < 15) begin
            send(t_kind'($urandom_range(0, 3)), 17'($urandom()));
            return;
        end
        if (pick >= 25)
            send(KIND_MARK, 17'(period + $urandom_range(0, 20) - 10));
        if (pick >= 20) begin
            send(KIND_RISE, 17'(r));
            if (pick >= 22)
                send(KIND_FALL, 17'(f));
        end
        send(KIND_TICK, 17'($urandom()));
    endtask

    initial begin
        int period;
        req_ch.valid    <= 1'b0;
        req_ch.kind     <= KIND_MARK;
        req_ch.stamp    <= '0;
        req_ch.overflow <= 1'b0;
        reg_ch.valid    <= 1'b0;
        reg_ch.index    <= CFG_OFFSET;
        reg_ch.data     <= '0;
        i_rst_n         <= 1'b0;
        snd_idle_pct    = 0;
        rcv_idle_pct    = 0;
        sent_items      = 0;
        sent_ticks      = 0;
        reg_writes      = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero period, no pulse, extreme stamps, wrap, odd widths
        send(KIND_TICK, 17'h00000);
        send(KIND_RISE, 17'h00010);
        send(KIND_FALL, 17'h00020);
        send(KIND_TICK, 17'h1FFFF);
        send(KIND_MARK, 17'h1FFFF);
        send(KIND_TICK, 17'h00000);
        send(KIND_RISE, 17'h00000);
        send(KIND_FALL, 17'h00000);
        send(KIND_TICK, 17'h00000);
        drain();
        send(KIND_RISE, 17'h0F000);
        send(KIND_FALL, 17'h00100);
        send(KIND_TICK, 17'h00000);
        send(KIND_RISE, 17'h00000);
        send(KIND_FALL, 17'h1FFFF);
        send(KIND_TICK, 17'h00000);
        send(KIND_RISE, 17'h1FFFF);
        send(KIND_FALL, 17'h00000);
        send(KIND_TICK, 17'h00000);
        send(KIND_RISE, 17'h00050);
        send(KIND_TICK, 17'h00000);
        send(KIND_MARK, 17'h00001);
        send(KIND_FALL, 17'h00003);
        send(KIND_TICK, 17'h00000);

        for (int seg = 0; seg < 6; seg++) begin
            case (seg)
                0: set_regs(0, 0, 359, 0);
                1: set_regs(359, 359, 0, 255);
                2: set_regs(180, 85, 275, 25);
                3: set_regs(0, 100, 100, 3);
                4: set_regs($urandom_range(0, 359), $urandom_range(0, 359),
                            $urandom_range(0, 359), $urandom_range(0, 255));
                default: set_regs(90, 0, 359, 1);
            endcase
            snd_idle_pct = (seg < 2) ? 18 : (seg < 4) ? 66 : 0;
            rcv_idle_pct = (seg < 2) ? 66 : (seg < 4) ? 18 : 0;
            period = ($urandom_range(0, 3) == 0) ? $urandom_range(20000, 131000)
                                                 : $urandom_range(200, 5000);
            for (int n = 0; n < 57; n++)
                beacon_turn(period);
        end

        drain();
        $display("covered %0d requests, %0d ticks, %0d register writes", sent_items,
                 sent_ticks, reg_writes);
        $display("six register settings, sender/receiver stalls swapped, then none");
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/ibad_pkg.sv
rtl/core/ibad_if.sv
rtl/core/ibad_div.sv
rtl/core/ibad_queue.sv
rtl/core/ibad_front.sv
rtl/core/ibad_back.sv
rtl/core/ir_beacon_angle_distance.sv
test/ibad_checker.sv
test/tb_ir_beacon_angle_distance.sv
